// ----- rtl/scc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Snooping cache coherence package
// Geometry constants, codes and shared types of the snooping tag controller.
// ----------------------------------------------------------------------------
package scc_pkg;
	localparam int SET_COUNT = 256;
	localparam int WAY_COUNT = 8;
	localparam int LINE_BYTES = 64;
	localparam int OFF_W = $clog2(LINE_BYTES);
	localparam int SET_W = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
	localparam int SET_B = $clog2(SET_COUNT);
	localparam int TAG_W = 32 - OFF_W - SET_B;
	localparam int RANK_W = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1;
	localparam int WAY_W = RANK_W;
	localparam int ROW_W = WAY_COUNT * TAG_W;
	localparam int SROW_W = WAY_COUNT * (3 + RANK_W);

	localparam logic [2:0] ST_I = 3'd0;
	localparam logic [2:0] ST_S = 3'd1;
	localparam logic [2:0] ST_E = 3'd2;
	localparam logic [2:0] ST_M = 3'd3;
	localparam logic [2:0] ST_SC = 3'd4;
	localparam logic [2:0] ST_SM = 3'd5;
	localparam logic [2:0] ST_PEND = 3'd6;

	localparam logic [2:0] RQ_NONE = 3'd0;
	localparam logic [2:0] RQ_RD = 3'd1;
	localparam logic [2:0] RQ_RDX = 3'd2;
	localparam logic [2:0] RQ_UPGR = 3'd3;
	localparam logic [2:0] RQ_UPD = 3'd4;

	localparam logic [1:0] K_RD = 2'd0;
	localparam logic [1:0] K_WR = 2'd1;
	localparam logic [1:0] K_SNOOP = 2'd2;
	localparam logic [1:0] K_RESP = 2'd3;

	localparam logic [1:0] MODE_MSI = 2'd0;
	localparam logic [1:0] MODE_MESI = 2'd1;
	localparam logic [1:0] MODE_DRAGON = 2'd2;

	localparam logic [1:0] PA_NONE = 2'd0;
	localparam logic [1:0] PA_RDMISS = 2'd1;
	localparam logic [1:0] PA_WRMISS = 2'd2;
	localparam logic [1:0] PA_WRHIT = 2'd3;

	typedef struct packed {
		logic [1:0] kind;
		logic [31:0] address;
		logic [2:0] snooped_operation;
		logic shared_line;
	} req_t;

	typedef struct packed {
		logic [2:0] issued_request;
		logic copy_present;
		logic hit;
		logic write_back;
		logic flush;
		logic intervention;
		logic invalidation;
		logic memory_transaction;
		logic cache_to_cache;
	} rsp_t;
endpackage
`default_nettype wire

// ----- rtl/scc_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Snooping cache coherence channel interfaces
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface scc_req_if;
	logic valid;
	logic ready;
	scc_pkg::req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface scc_rsp_if;
	logic valid;
	logic ready;
	scc_pkg::rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/snooping_cache_coherence.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Snooping cache coherence tag controller
// Set-associative LRU tag store with MSI, MESI or Dragon line states.
//
// A request transaction on req (read, write, snoop or shared response)
// produces exactly one result transaction on rsp. The user must write
// protocol_mode through cfg_we/cfg_data only while the block is idle; the
// block itself does not enforce this. Each transaction passes three steps:
// accept, read of the set row from the tag and state memories, then
// decision and write-back of the row. One transaction is in flight at a
// time: a new request is accepted only in the idle state and when the
// result register is empty or its result is taken in the same cycle.
// After reset a clearing pass sweeps the state memory one set per cycle,
// over every set, before the first request is accepted.
// When rsp stalls, a finished result waits in the output register and the
// next request is held until that register is free.
// ----------------------------------------------------------------------------
module snooping_cache_coherence (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [1:0] cfg_data,
	scc_req_if.sink req,
	scc_rsp_if.source rsp
);
	import scc_pkg::*;

	typedef enum logic [1:0] {CLEAR, IDLE, LOOK, DECIDE} state_t;

	state_t state_q;
	logic [SET_W-1:0] clr_q;
	logic [1:0] mode_q;
	logic [1:0] pend_q;
	logic upg_q;
	logic [2:0] lreq_q;
	req_t item_q;
	rsp_t out_q;
	logic out_v_q;

	logic [SET_W-1:0] set_idx;
	logic [TAG_W-1:0] tag;
	logic [ROW_W-1:0] trow, trow_n;
	logic [SROW_W-1:0] srow, srow_n;
	logic t_we, s_we;
	logic [SET_W-1:0] s_waddr;

	always_comb begin
		set_idx = SET_W'((SET_B > 0) ? (item_q.address >> OFF_W) : 0);
		tag = TAG_W'(item_q.address >> (OFF_W + SET_B));
	end

	scc_ram #(.WIDTH(ROW_W), .DEPTH(SET_COUNT)) u_tag (
		.clk(clk), .we(t_we), .waddr(set_idx), .wdata(trow_n),
		.raddr(set_idx), .rdata(trow)
	);
	scc_ram #(.WIDTH(SROW_W), .DEPTH(SET_COUNT)) u_stat (
		.clk(clk), .we(s_we), .waddr(s_waddr), .wdata(srow_n),
		.raddr(set_idx), .rdata(srow)
	);

	logic [2:0] st_a [WAY_COUNT];
	logic [RANK_W-1:0] rk_a [WAY_COUNT];
	logic [2:0] st_n [WAY_COUNT];
	logic [RANK_W-1:0] rk_n [WAY_COUNT];
	logic hitf, inv_f;
	logic [WAY_W-1:0] hw, iw, lw, vw;
	logic [RANK_W-1:0] mn;
	logic [1:0] mode;
	logic [1:0] pend_n;
	logic upg_n;
	logic [2:0] lreq_n;
	rsp_t r;
	logic [2:0] st;
	logic wr, touch_en;

	always_comb begin
		mode = (mode_q == 2'd3) ? MODE_MSI : mode_q;
		hitf = 1'b0; hw = '0; inv_f = 1'b0; iw = '0; lw = '0; mn = '1;
		for (int w = 0; w < WAY_COUNT; w++) begin
			st_a[w] = srow[w*(3+RANK_W) +: 3];
			rk_a[w] = srow[w*(3+RANK_W)+3 +: RANK_W];
		end
		for (int w = WAY_COUNT - 1; w >= 0; w--) begin
			if (st_a[w] != ST_I && trow[w*TAG_W +: TAG_W] == tag) begin
				hitf = 1'b1; hw = WAY_W'(w);
			end
			if (st_a[w] == ST_I) begin
				inv_f = 1'b1; iw = WAY_W'(w);
			end
		end
		for (int w = 0; w < WAY_COUNT; w++) begin
			if (rk_a[w] <= mn) begin
				mn = rk_a[w]; lw = WAY_W'(w);
			end
		end
		vw = hitf ? hw : (inv_f ? iw : lw);
		st = st_a[vw];
		wr = (item_q.kind == K_WR);
		r = '0; pend_n = pend_q; upg_n = upg_q; lreq_n = lreq_q; touch_en = 1'b0;
		for (int w = 0; w < WAY_COUNT; w++) begin
			st_n[w] = st_a[w]; rk_n[w] = rk_a[w];
		end
		trow_n = trow;
		trow_n[vw*TAG_W +: TAG_W] = tag;
		unique case (item_q.kind)
			K_RD, K_WR: begin
				touch_en = 1'b1; upg_n = 1'b0; lreq_n = RQ_NONE;
				if (!hitf) begin
					r.write_back = (st == ST_M || st == ST_SM);
					if (wr) begin
						pend_n = PA_WRMISS;
						if (mode == MODE_MSI) begin
							st_n[vw] = ST_M; lreq_n = RQ_RDX; r.memory_transaction = 1'b1;
						end else if (mode == MODE_MESI) begin
							st_n[vw] = ST_M; lreq_n = RQ_RDX;
						end else begin
							st_n[vw] = ST_PEND; lreq_n = RQ_RD; r.memory_transaction = 1'b1;
						end
					end else begin
						pend_n = PA_RDMISS; lreq_n = RQ_RD;
						st_n[vw] = (mode == MODE_MSI) ? ST_S : ST_PEND;
						r.memory_transaction = (mode != MODE_MESI);
					end
				end else begin
					r.hit = 1'b1;
					pend_n = wr ? PA_WRHIT : PA_NONE;
					if (wr) begin
						if (mode == MODE_MSI) begin
							if (st == ST_S) begin
								st_n[vw] = ST_M; lreq_n = RQ_RDX; r.memory_transaction = 1'b1;
							end
						end else if (mode == MODE_MESI) begin
							if (st == ST_S) begin
								st_n[vw] = ST_M; lreq_n = RQ_UPGR; upg_n = 1'b1;
							end else if (st == ST_E) begin
								st_n[vw] = ST_M;
							end
						end else begin
							if (st == ST_E) st_n[vw] = ST_M;
							else if (st == ST_SC || st == ST_SM) lreq_n = RQ_UPD;
						end
					end
				end
				r.issued_request = lreq_n;
			end
			K_SNOOP: begin
				if (hitf) begin
					if (mode == MODE_MSI) begin
						if (st == ST_S && item_q.snooped_operation == RQ_RDX) begin
							st_n[vw] = ST_I; r.invalidation = 1'b1;
						end else if (st == ST_M && item_q.snooped_operation == RQ_RDX) begin
							st_n[vw] = ST_I; r.invalidation = 1'b1; r.write_back = 1'b1;
							r.flush = 1'b1; r.memory_transaction = 1'b1;
						end else if (st == ST_M && item_q.snooped_operation == RQ_RD) begin
							st_n[vw] = ST_S; r.write_back = 1'b1; r.intervention = 1'b1;
							r.flush = 1'b1; r.memory_transaction = 1'b1;
						end
					end else if (mode == MODE_MESI) begin
						if (st == ST_M) begin
							r.copy_present = 1'b1;
							if (item_q.snooped_operation == RQ_RD) begin
								st_n[vw] = ST_S; r.write_back = 1'b1; r.intervention = 1'b1;
								r.flush = 1'b1; r.memory_transaction = 1'b1;
							end else if (item_q.snooped_operation == RQ_RDX) begin
								st_n[vw] = ST_I; r.write_back = 1'b1; r.invalidation = 1'b1;
								r.flush = 1'b1; r.memory_transaction = 1'b1;
							end
						end else if (st == ST_E) begin
							r.copy_present = 1'b1;
							if (item_q.snooped_operation == RQ_RD) begin
								st_n[vw] = ST_S; r.intervention = 1'b1;
							end else if (item_q.snooped_operation == RQ_RDX) begin
								st_n[vw] = ST_I; r.invalidation = 1'b1;
							end
						end else if (st == ST_S) begin
							r.copy_present = 1'b1;
							if (item_q.snooped_operation == RQ_RDX
									|| item_q.snooped_operation == RQ_UPGR) begin
								st_n[vw] = ST_I; r.invalidation = 1'b1;
							end
						end
					end else begin
						if (st == ST_M) begin
							r.copy_present = 1'b1;
							if (item_q.snooped_operation == RQ_RD) begin
								st_n[vw] = ST_SM; r.intervention = 1'b1; r.flush = 1'b1;
							end
						end else if (st == ST_E) begin
							r.copy_present = 1'b1;
							if (item_q.snooped_operation == RQ_RD) begin
								st_n[vw] = ST_SC; r.intervention = 1'b1;
							end
						end else if (st == ST_SC) begin
							r.copy_present = 1'b1;
						end else if (st == ST_SM) begin
							r.copy_present = 1'b1;
							if (item_q.snooped_operation == RQ_RD) r.flush = 1'b1;
							else if (item_q.snooped_operation == RQ_UPD) st_n[vw] = ST_SC;
						end
					end
				end
			end
			K_RESP: begin
				if (lreq_q != RQ_NONE && hitf && mode != MODE_MSI) begin
					if (mode == MODE_MESI) begin
						if (pend_q == PA_RDMISS) begin
							if (item_q.shared_line) st_n[vw] = ST_S;
							else begin
								st_n[vw] = ST_E; r.memory_transaction = 1'b1;
							end
						end
						if (pend_q == PA_WRMISS && !item_q.shared_line)
							r.memory_transaction = 1'b1;
						r.cache_to_cache = item_q.shared_line && !upg_q;
					end else begin
						lreq_n = RQ_NONE;
						if (pend_q == PA_RDMISS) begin
							st_n[vw] = item_q.shared_line ? ST_SC : ST_E;
						end else if (pend_q == PA_WRMISS) begin
							if (item_q.shared_line) begin
								st_n[vw] = ST_SM; lreq_n = RQ_UPD;
							end else st_n[vw] = ST_M;
						end else if (pend_q == PA_WRHIT) begin
							if (st == ST_SC || st == ST_SM)
								st_n[vw] = item_q.shared_line ? ST_SM : ST_M;
						end
						r.issued_request = lreq_n;
					end
				end
			end
			default: ;
		endcase
		if (touch_en) begin
			for (int w = 0; w < WAY_COUNT; w++) begin
				if (rk_a[w] > rk_a[vw]) rk_n[w] = rk_a[w] - 1'b1;
			end
			rk_n[vw] = RANK_W'(WAY_COUNT - 1);
		end
		for (int w = 0; w < WAY_COUNT; w++) begin
			srow_n[w*(3+RANK_W) +: 3+RANK_W] = (state_q == CLEAR) ? '0 : {rk_n[w], st_n[w]};
		end
		t_we = (state_q == DECIDE) && touch_en && !hitf;
		s_we = (state_q == CLEAR) || (state_q == DECIDE);
		s_waddr = (state_q == CLEAR) ? clr_q : set_idx;
	end

	assign req.ready = (state_q == IDLE) && (!out_v_q || rsp.ready);
	assign rsp.valid = out_v_q;
	assign rsp.data = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CLEAR;
			clr_q <= '0;
			mode_q <= MODE_MSI;
			pend_q <= PA_NONE;
			upg_q <= 1'b0;
			lreq_q <= RQ_NONE;
			out_v_q <= 1'b0;
		end else begin
			if (cfg_we) mode_q <= cfg_data;
			if (out_v_q && rsp.ready) out_v_q <= 1'b0;
			unique case (state_q)
				CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == SET_W'(SET_COUNT - 1)) state_q <= IDLE;
				end
				IDLE: if (req.valid && req.ready) state_q <= LOOK;
				LOOK: state_q <= DECIDE;
				DECIDE: begin
					out_v_q <= 1'b1;
					pend_q <= pend_n;
					upg_q <= upg_n;
					lreq_q <= lreq_n;
					state_q <= IDLE;
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) item_q <= req.data;
		if (state_q == DECIDE) out_q <= r;
	end

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |-> state_q == IDLE)
		else $error("request accepted while busy");
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == DECIDE |=> out_v_q)
		else $error("result missing after decision");
	a_hit_proc: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == DECIDE && r.hit) |-> (item_q.kind == K_RD || item_q.kind == K_WR))
		else $error("hit on non-processor transaction");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == DECIDE) |-> (!out_v_q || rsp.ready || $past(!out_v_q)))
		else $error("result overwritten");
endmodule
`default_nettype wire

// ----- rtl/scc_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module scc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire
